[hdl/rtdsl_pkg.sv]
// types, codes and calendar helpers shared by the reminder table
`default_nettype none

package rtdsl_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int CFG_W       = 5;
    localparam int KEY_W       = 11;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_NEXT_DAY = 2'd1,
        OP_LIST     = 2'd2
    } rtdsl_op_t;

    typedef enum logic {
        CFG_START_MONTH = 1'b0,
        CFG_START_DAY   = 1'b1
    } rtdsl_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } rtdsl_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] message_handle;
    } rtdsl_in_t;

    typedef struct packed {
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_handle;
        logic        empty_res;
        logic        table_full;
        logic        last;
    } rtdsl_out_t;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] handle;
    } rtdsl_entry_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } rtdsl_date_t;

    // control from the sequencer to every sort cell
    typedef struct packed {
        logic feed;
        logic pop;
    } rtdsl_sort_ctl_t;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic [KEY_W-1:0] time_key(input rtdsl_entry_t e);
        time_key = {e.hour, e.minute};
    endfunction

    function automatic rtdsl_date_t next_date(input logic [3:0] m, input logic [4:0] d);
        rtdsl_date_t r;
        r.month = m;
        r.day   = d + 5'd1;
        if (m == 4'd0 || m > 4'd12)
        begin
            r.month = 4'd1;
            r.day   = 5'd1;
        end
        else if (d >= MONTH_LEN[m - 4'd1])
        begin
            r.day   = 5'd1;
            r.month = (m == 4'd12) ? 4'd1 : m + 4'd1;
        end
        next_date = r;
    endfunction

endpackage

`default_nettype wire

[hdl/rtdsl_chan_if.sv]
// valid/ready channel carrying one item of a given payload type
`default_nettype none

interface rtdsl_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/rtdsl_store_cell.sv]
// one table entry of the rotating reminder ring
`default_nettype none

module rtdsl_store_cell (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire rtdsl_pkg::rtdsl_entry_t wr_data,
    input  wire logic                  shift_en,
    input  wire rtdsl_pkg::rtdsl_entry_t nb_data,
    output rtdsl_pkg::rtdsl_entry_t      data
);
    import rtdsl_pkg::*;

    rtdsl_entry_t data_reg;
    rtdsl_entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = nb_data;
        end
        else if (wr_en)
        begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[hdl/rtdsl_sort_cell.sv]
// one slot of the insertion sorter: takes a fed item or the upper neighbor, pops from below
`default_nettype none

module rtdsl_sort_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rtdsl_pkg::rtdsl_sort_ctl_t ctl,
    input  wire rtdsl_pkg::rtdsl_entry_t    feed_entry,
    input  wire logic                     prev_ins,
    input  wire logic                     above_valid,
    input  wire rtdsl_pkg::rtdsl_entry_t    above_entry,
    input  wire logic                     below_valid,
    input  wire rtdsl_pkg::rtdsl_entry_t    below_entry,
    output logic                          ins,
    output logic                          valid,
    output rtdsl_pkg::rtdsl_entry_t         entry
);
    import rtdsl_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    rtdsl_entry_t entry_reg;
    rtdsl_entry_t entry_next;

    // strict less keeps equal times in arrival order
    assign ins = ctl.feed && (!valid_reg || (time_key(feed_entry) < time_key(entry_reg)));

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.pop)
        begin
            valid_next = below_valid;
            entry_next = below_entry;
        end
        else if (ins)
        begin
            if (prev_ins)
            begin
                valid_next = above_valid;
                entry_next = above_entry;
            end
            else
            begin
                valid_next = 1'b1;
                entry_next = feed_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

[hdl/reminder_table_daily_sorted_list.sv]
// add and next_day: the result is registered and shows the cycle after acceptance
// list: the table ring rotates once around past the sorter, then one result per cycle
//   while the result side is ready (at most 32)
// the rotation of the table ring through one comparator stage sets the list time
// reset: entry count zero, date January 1, sorter empty; table contents are not cleared
`default_nettype none

module reminder_table_daily_sorted_list #(
    parameter int CAPACITY = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rtdsl_chan_if.sink                       command,
    rtdsl_chan_if.source                     result,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [rtdsl_pkg::CFG_W-1:0] cfg_data
);
    import rtdsl_pkg::*;

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SORT_DEPTH = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    rtdsl_state_t    state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [3:0]      month_reg, month_next;
    logic [4:0]      day_reg, day_next;
    logic            res_valid_reg, res_valid_next;
    rtdsl_out_t      result_reg, result_next;

    rtdsl_in_t       cmd;
    rtdsl_entry_t    new_entry;
    rtdsl_date_t     adv_date;
    logic            cmd_go;
    logic            out_free;
    logic            add_write;
    logic            scan_shift;
    rtdsl_sort_ctl_t sort_ctl;

    rtdsl_entry_t    store_q  [CAPACITY];
    logic            store_wr [CAPACITY];

    // sorter slots sit at 1..SORT_DEPTH, 0 and SORT_DEPTH+1 are empty borders
    logic            slot_valid [SORT_DEPTH+2];
    rtdsl_entry_t    slot_entry [SORT_DEPTH+2];
    logic            slot_ins   [SORT_DEPTH+1];

    assign cmd       = command.payload;
    assign out_free  = !res_valid_reg || result.ready;
    assign command.ready = (state_reg == ST_IDLE) && out_free;
    assign cmd_go    = command.valid && command.ready;
    assign adv_date  = next_date(month_reg, day_reg);

    assign new_entry.month  = cmd.month;
    assign new_entry.day    = cmd.day;
    assign new_entry.hour   = cmd.hour;
    assign new_entry.minute = cmd.minute;
    assign new_entry.handle = cmd.message_handle;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_store
            assign store_wr[gi] = add_write && (count_reg == CNT_W'(gi));
            rtdsl_store_cell u_cell (
                .clk      (clk),
                .wr_en    (store_wr[gi]),
                .wr_data  (new_entry),
                .shift_en (scan_shift),
                .nb_data  (store_q[(gi + 1) % CAPACITY]),
                .data     (store_q[gi])
            );
        end

        for (gi = 0; gi < SORT_DEPTH; gi++)
        begin : g_sort
            rtdsl_sort_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (sort_ctl),
                .feed_entry  (store_q[0]),
                .prev_ins    (slot_ins[gi]),
                .above_valid (slot_valid[gi]),
                .above_entry (slot_entry[gi]),
                .below_valid (slot_valid[gi+2]),
                .below_entry (slot_entry[gi+2]),
                .ins         (slot_ins[gi+1]),
                .valid       (slot_valid[gi+1]),
                .entry       (slot_entry[gi+1])
            );
        end
    endgenerate

    assign slot_ins[0]              = 1'b0;
    assign slot_valid[0]            = 1'b0;
    assign slot_entry[0]            = '0;
    assign slot_valid[SORT_DEPTH+1] = 1'b0;
    assign slot_entry[SORT_DEPTH+1] = '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        res_valid_next = res_valid_reg && !result.ready;
        result_next    = result_reg;
        add_write      = 1'b0;
        scan_shift     = 1'b0;
        sort_ctl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_go)
                begin
                    case (cmd.operation)
                        OP_ADD:
                        begin
                            result_next      = '0;
                            result_next.last = 1'b1;
                            res_valid_next   = 1'b1;
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                add_write  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                result_next.table_full = 1'b1;
                            end
                        end
                        OP_NEXT_DAY:
                        begin
                            month_next            = adv_date.month;
                            day_next              = adv_date.day;
                            result_next           = '0;
                            result_next.out_month = adv_date.month;
                            result_next.out_day   = adv_date.day;
                            result_next.last      = 1'b1;
                            res_valid_next        = 1'b1;
                        end
                        OP_LIST:
                        begin
                            state_next = ST_SCAN;
                            scan_next  = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // the ring rotates once around; entry k sits at the head on step k
                scan_shift    = 1'b1;
                sort_ctl.feed = (scan_reg < count_reg) && (store_q[0].month == month_reg)
                                && (store_q[0].day == day_reg);
                scan_next     = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(CAPACITY - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    result_next    = '0;
                    res_valid_next = 1'b1;
                    if (slot_valid[1])
                    begin
                        sort_ctl.pop           = 1'b1;
                        result_next.out_month  = slot_entry[1].month;
                        result_next.out_day    = slot_entry[1].day;
                        result_next.out_hour   = slot_entry[1].hour;
                        result_next.out_minute = slot_entry[1].minute;
                        result_next.out_handle = slot_entry[1].handle;
                        result_next.last       = !slot_valid[2];
                        if (!slot_valid[2])
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // nothing matched today
                        result_next.empty_res = 1'b1;
                        result_next.last      = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_MONTH: month_next = cfg_data[3:0];
                CFG_START_DAY:   day_next   = cfg_data;
                default:         month_next = month_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_sorter_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !slot_valid[1])
        else $error("sorter holds items while idle");

    a_sorter_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !slot_valid[1] |-> !slot_valid[2])
        else $error("sorter slots not packed toward the head");

    a_list_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_go && cmd.operation == OP_LIST |=> state_reg == ST_SCAN)
        else $error("list item did not start a scan");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && result_reg.empty_res |-> result_reg.last)
        else $error("empty listing result not marked last");
`endif

endmodule

`default_nettype wire

[tb/reminder_table_daily_sorted_list_tb.sv]
// self-checking testbench for the reminder table with date stepping and sorted daily listing
`default_nettype none

module reminder_table_daily_sorted_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtdsl_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int SETTLE       = 80;
    localparam int LIMIT        = 600000;
    localparam int RANDOM_ITEMS = 480;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [4:0] DAYS_IN_MONTH [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct {
        bit                 is_cfg;
        rtdsl_cfg_idx_t     reg_idx;
        logic [CFG_W-1:0]   reg_val;
        rtdsl_in_t          cmd;
        bit                 typed;
        rtdsl_out_t         exp;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    rtdsl_chan_if #(.payload_t(rtdsl_in_t))  command_ch ();
    rtdsl_chan_if #(.payload_t(rtdsl_out_t)) result_ch ();

    reminder_table_daily_sorted_list #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .command(command_ch),
        .result(result_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predicted state of the block
    rtdsl_entry_t notes [CAPACITY];
    int unsigned  note_count;
    logic [3:0]   today_month;
    logic [4:0]   today_day;
    rtdsl_out_t   fresh [$];
    rtdsl_out_t   due_results [$];

    // directed stimulus rows, walked in order
    plan_row_t    plan [$];

    bit no_idle;
    int unsigned cycles = 0;
    int faults = 0;
    int n_add, n_full, n_days, n_list, n_listed, n_empty;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_results.size());
            $display("reminder_table_daily_sorted_list_tb: FAIL");
            $finish;
        end
    end

    function automatic void stage_row(input plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic logic [8:0] day_after(input logic [3:0] m, input logic [4:0] d);
        if (m == 4'd0 || m > 4'd12)
            return {4'd1, 5'd1};
        if (d >= DAYS_IN_MONTH[m - 4'd1])
            return {((m == 4'd12) ? 4'd1 : m + 4'd1), 5'd1};
        return {m, d + 5'd1};
    endfunction

    // fills fresh with the results one command item causes and updates the state
    task automatic predict(input rtdsl_in_t c);
        rtdsl_out_t r;
        int hits [$];
        int tmp;
        int i;
        int j;
        int shown;
        fresh.delete();
        r = '0;
        r.last = 1'b1;
        case (c.operation)
            OP_ADD:
            begin
                if (note_count < CAPACITY)
                begin
                    notes[note_count] = '{c.month, c.day, c.hour, c.minute, c.message_handle};
                    note_count++;
                end
                else
                    r.table_full = 1'b1;
                fresh.insert(fresh.size(), r);
            end
            OP_NEXT_DAY:
            begin
                {today_month, today_day} = day_after(today_month, today_day);
                r.out_month = today_month;
                r.out_day   = today_day;
                fresh.insert(fresh.size(), r);
            end
            OP_LIST:
            begin
                for (i = 0; i < note_count; i++)
                    if (notes[i].month == today_month && notes[i].day == today_day)
                        hits.insert(hits.size(), i);
                if (hits.size() == 0)
                begin
                    r.empty_res = 1'b1;
                    fresh.insert(fresh.size(), r);
                end
                else
                begin
                    // stable insertion sort on hour:minute
                    for (i = 1; i < hits.size(); i++)
                    begin
                        tmp = hits[i];
                        j = i;
                        while (j > 0 && {notes[hits[j-1]].hour, notes[hits[j-1]].minute} >
                                        {notes[tmp].hour, notes[tmp].minute})
                        begin
                            hits[j] = hits[j-1];
                            j--;
                        end
                        hits[j] = tmp;
                    end
                    shown = (hits.size() > MAX_RESULTS) ? MAX_RESULTS : hits.size();
                    for (i = 0; i < shown; i++)
                    begin
                        r = '0;
                        r.out_month  = notes[hits[i]].month;
                        r.out_day    = notes[hits[i]].day;
                        r.out_hour   = notes[hits[i]].hour;
                        r.out_minute = notes[hits[i]].minute;
                        r.out_handle = notes[hits[i]].handle;
                        r.last       = (i == shown - 1);
                        fresh.insert(fresh.size(), r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send(input rtdsl_in_t c, input bit typed, input rtdsl_out_t exp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            command_ch.valid <= 1'b0;
            @(posedge clk);
        end
        command_ch.valid   <= 1'b1;
        command_ch.payload <= c;
        do
            @(posedge clk);
        while (!command_ch.ready);
        predict(c);
        if (typed)
            due_results.insert(due_results.size(), exp);
        else
            foreach (fresh[i])
                due_results.insert(due_results.size(), fresh[i]);
        case (c.operation)
            OP_ADD:
            begin
                n_add++;
                if (fresh[0].table_full)
                    n_full++;
            end
            OP_NEXT_DAY:
                n_days++;
            OP_LIST:
            begin
                n_list++;
                if (fresh[0].empty_res)
                    n_empty++;
                else
                    n_listed += fresh.size();
            end
            default:
            begin
            end
        endcase
    endtask

    // register writes only once the block has drained and settled
    task automatic write_reg(input rtdsl_cfg_idx_t idx, input logic [CFG_W-1:0] val);
        command_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_START_MONTH)
            today_month = val[3:0];
        else
            today_day = val[4:0];
    endtask

    function automatic plan_row_t cmd_row(input logic [1:0] op, input logic [3:0] m,
                                          input logic [4:0] d, input logic [4:0] h,
                                          input logic [5:0] mi, input logic [15:0] hd,
                                          input bit typed = 1'b0,
                                          input rtdsl_out_t exp = '0);
        plan_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = CFG_START_MONTH;
        r.reg_val = '0;
        r.cmd     = '{op, m, d, h, mi, hd};
        r.typed   = typed;
        r.exp     = exp;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input rtdsl_cfg_idx_t idx,
                                          input logic [CFG_W-1:0] val);
        plan_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.cmd     = '0;
        r.typed   = 1'b0;
        r.exp     = '0;
        return r;
    endfunction

    function automatic rtdsl_out_t typed_result(input logic [3:0] m, input logic [4:0] d,
                                                input bit empty, input bit full);
        rtdsl_out_t r;
        r = '0;
        r.out_month  = m;
        r.out_day    = d;
        r.empty_res  = empty;
        r.table_full = full;
        r.last       = 1'b1;
        return r;
    endfunction

    // result side: random stalls, compare each item with the oldest expectation
    initial
    begin
        int stall;
        rtdsl_out_t got;
        rtdsl_out_t want;
        result_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            repeat (stall)
            begin
                result_ch.ready <= 1'b0;
                @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got = result_ch.payload;
            if (due_results.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result at cycle %0d: %0d/%0d %0d:%0d h=%h e=%b f=%b l=%b",
                             cycles, got.out_month, got.out_day, got.out_hour, got.out_minute,
                             got.out_handle, got.empty_res, got.table_full, got.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.out_month !== want.out_month || got.out_day !== want.out_day ||
                    got.out_hour !== want.out_hour || got.out_minute !== want.out_minute ||
                    got.out_handle !== want.out_handle || got.empty_res !== want.empty_res ||
                    got.table_full !== want.table_full || got.last !== want.last)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  expected %0d/%0d %0d:%0d h=%h e=%b f=%b l=%b",
                                 want.out_month, want.out_day, want.out_hour, want.out_minute,
                                 want.out_handle, want.empty_res, want.table_full, want.last);
                        $display("  actual   %0d/%0d %0d:%0d h=%h e=%b f=%b l=%b",
                                 got.out_month, got.out_day, got.out_hour, got.out_minute,
                                 got.out_handle, got.empty_res, got.table_full, got.last);
                    end
                end
            end
        end
    end

    initial
    begin
        rtdsl_in_t c;
        rtdsl_entry_t pick_note;
        logic [8:0] when;
        logic [3:0] m;
        logic [4:0] d;
        int items;
        int phase;
        int len;
        int pick;
        int add_cut;
        int ahead;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = 1'b0;
        cfg_data           = '0;
        command_ch.valid   = 1'b0;
        command_ch.payload = '0;
        no_idle            = 1'b0;
        note_count         = 0;
        today_month        = 4'd1;
        today_day          = 5'd1;
        n_add = 0; n_full = 0; n_days = 0; n_list = 0; n_listed = 0; n_empty = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        stage_row(cmd_row(OP_LIST, 0, 0, 0, 0, 0, 1, typed_result(0, 0, 1, 0)));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(1, 2, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 9, 30, 16'h1234, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 9, 30, 16'h1235, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 0, 0, 16'h0000, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 31, 63, 16'hffff, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 8, 59, 16'h00aa, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 1, 2, 9, 29, 16'h5a5a, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_LIST, 0, 0, 0, 0, 0));
        stage_row(cmd_row(OP_ADD, 15, 31, 31, 63, 16'hffff, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_ADD, 0, 0, 0, 0, 16'h0000, 1, typed_result(0, 0, 0, 0)));
        stage_row(cmd_row(OP_NONE, 15, 31, 31, 63, 16'hffff));
        // year wrap
        stage_row(cfg_row(CFG_START_MONTH, 5'd12));
        stage_row(cfg_row(CFG_START_DAY, 5'd31));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(1, 1, 0, 0)));
        // end of february, and a day past the month length
        stage_row(cfg_row(CFG_START_MONTH, 5'd2));
        stage_row(cfg_row(CFG_START_DAY, 5'd28));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(3, 1, 0, 0)));
        stage_row(cfg_row(CFG_START_MONTH, 5'd2));
        stage_row(cfg_row(CFG_START_DAY, 5'd31));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(3, 1, 0, 0)));
        // invalid months list their own odd entries, then step to january 1
        stage_row(cfg_row(CFG_START_MONTH, 5'd0));
        stage_row(cfg_row(CFG_START_DAY, 5'd0));
        stage_row(cmd_row(OP_LIST, 0, 0, 0, 0, 0));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(1, 1, 0, 0)));
        stage_row(cfg_row(CFG_START_MONTH, 5'd15));
        stage_row(cfg_row(CFG_START_DAY, 5'd31));
        stage_row(cmd_row(OP_LIST, 0, 0, 0, 0, 0));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(1, 1, 0, 0)));
        // day zero, and a 30-day month end
        stage_row(cfg_row(CFG_START_MONTH, 5'd4));
        stage_row(cfg_row(CFG_START_DAY, 5'd0));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(4, 1, 0, 0)));
        stage_row(cfg_row(CFG_START_DAY, 5'd30));
        stage_row(cmd_row(OP_NEXT_DAY, 0, 0, 0, 0, 0, 1, typed_result(5, 1, 0, 0)));

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                send(plan[k].cmd, plan[k].typed, plan[k].exp);
        end

        // random part: each stretch starts from a date, mostly one that has entries
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            no_idle = (phase % 4 == 3);
            if (note_count > 0 && $urandom_range(0, 9) < 7)
            begin
                pick_note = notes[$urandom_range(0, note_count - 1)];
                m = pick_note.month;
                d = pick_note.day;
                if ($urandom_range(0, 2) == 0 && d > 0)
                    d = d - 5'd1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m = 4'($urandom);
                d = 5'($urandom);
            end
            else
            begin
                m = 4'($urandom_range(1, 12));
                d = 5'($urandom_range(1, DAYS_IN_MONTH[m - 4'd1]));
            end
            write_reg(CFG_START_MONTH, {1'($urandom), m});
            write_reg(CFG_START_DAY, d);

            len = $urandom_range(20, 45);
            repeat (len)
            begin
                c.month          = 4'($urandom);
                c.day            = 5'($urandom);
                c.hour           = 5'($urandom);
                c.minute         = 6'($urandom);
                c.message_handle = 16'($urandom);
                add_cut = (note_count < CAPACITY) ? 45 : 15;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    c.operation = OP_NONE;
                else if (pick < add_cut)
                begin
                    c.operation = OP_ADD;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        // land on today or one of the next two days
                        when = {today_month, today_day};
                        ahead = $urandom_range(0, 2);
                        repeat (ahead) when = day_after(when[8:5], when[4:0]);
                        {c.month, c.day} = when;
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        // few distinct times so equal keys show up
                        c.hour   = 5'($urandom_range(7, 9));
                        c.minute = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd30;
                    end
                end
                else if (pick < add_cut + 20)
                    c.operation = OP_NEXT_DAY;
                else
                    c.operation = OP_LIST;
                send(c, 1'b0, '0);
                if (c.operation != OP_NONE)
                    items++;
            end
            phase++;
        end

        command_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d adds (%0d dropped as full), %0d day steps, %0d listings in %0d stretches",
                 n_add, n_full, n_days, n_list, phase);
        $display("listings gave %0d entries and %0d empty answers; %0d mismatches",
                 n_listed, n_empty, faults);
        if (faults == 0)
            $display("reminder_table_daily_sorted_list_tb: PASS");
        else
            $display("reminder_table_daily_sorted_list_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
